### src/mnt_pkg.sv
// ----------------------------------------------------------------------------
// mnt_pkg
// shared types and constants for the midi note tracker
// ----------------------------------------------------------------------------
`default_nettype none

package mnt_pkg;

  localparam int unsigned TICK_W   = 32;
  localparam int unsigned DELTA_W  = 28;
  localparam int unsigned PITCH_W  = 7;
  localparam int unsigned VOL_W    = 7;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_DAMPER   = 2'd2,
    CMD_OTHER    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NOTE        = 2'd0,
    KIND_DAMPER_SPAN = 2'd1,
    KIND_OFF_NO_ON   = 2'd2,
    KIND_UP_NO_DOWN  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [VOL_W-1:0]  volume;
    logic [TICK_W-1:0] start;
  } slot_data_t;

endpackage

`default_nettype wire

### src/mnt_slot_ram.sv
// ----------------------------------------------------------------------------
// mnt_slot_ram
// per-pitch slot store, one write and one registered read per cycle,
// write data forwarded when both ports hit the same entry
// ----------------------------------------------------------------------------
`default_nettype none

module mnt_slot_ram
  import mnt_pkg::*;
#(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned IDX_W = 7
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire slot_data_t       wdata,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output slot_data_t            rdata
);

  slot_data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

`default_nettype wire

### src/midi_event_to_note_tracker.sv
// ----------------------------------------------------------------------------
// midi_event_to_note_tracker
// pairs note-on/note-off and damper down/up events into timed spans
// ----------------------------------------------------------------------------
// Takes one event per clock cycle. The running tick count (saturating at
// 2^32-1) is advanced as an event is taken; the event then passes through a
// slot read-modify-write stage, where the start tick and volume for its
// pitch live in a memory with a registered read and valid bits in
// flip-flops. Any result is written to the output register as the event
// leaves the stage. An event that follows a note-on of the same pitch in
// the next cycle sees the new slot through write forwarding. Reset clears
// the valid bits at once, so no clearing pass is needed. The input stalls
// only while a result is held in the stage and the output register is full
// and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_event_to_note_tracker
  import mnt_pkg::*;
#(
  parameter int unsigned PITCH_SLOTS = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         cmd,
  input  wire logic [DELTA_W-1:0] delta_ticks,
  input  wire logic [PITCH_W-1:0] pitch_or_pedal,
  input  wire logic [VOL_W-1:0]   velocity,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              kind,
  output logic [PITCH_W-1:0]      note_pitch,
  output logic [VOL_W-1:0]        note_volume,
  output logic [TICK_W-1:0]       start_tick,
  output logic [TICK_W-1:0]       stop_tick
);

  localparam int unsigned IDX_W = (PITCH_SLOTS > 1) ? $clog2(PITCH_SLOTS) : 1;
  localparam int unsigned CMP_W = PITCH_W + 2;

  // tick count
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W:0]   tick_sum;
  logic [TICK_W-1:0] tick_next;

  // slot stage
  logic              s1_valid;
  cmd_t              s1_cmd;
  logic [PITCH_W-1:0] s1_pitch;
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_in_range;
  logic              s1_pedal_down;
  logic [VOL_W-1:0]  s1_vel;
  logic [TICK_W-1:0] s1_now;
  logic              s1_has_result;
  logic              s1_hold;
  logic              s1_fire;

  logic [PITCH_SLOTS-1:0] slot_valid;
  logic                   damper_held;
  logic [TICK_W-1:0]      damper_start;

  logic             accept;
  logic [IDX_W-1:0] in_idx;
  logic             in_range;

  logic             ram_we;
  slot_data_t       ram_wdata;
  slot_data_t       ram_rdata;
  logic             slot_hit;

  kind_t             res_kind;
  logic [PITCH_W-1:0] res_pitch;
  logic [VOL_W-1:0]  res_volume;
  logic [TICK_W-1:0] res_start;

  assign tick_sum  = {1'b0, tick_count} + {{(TICK_W + 1 - DELTA_W){1'b0}}, delta_ticks};
  assign tick_next = tick_sum[TICK_W] ? TICK_MAX : tick_sum[TICK_W-1:0];

  assign in_idx   = IDX_W'(pitch_or_pedal);
  assign in_range = {2'b00, pitch_or_pedal} < CMP_W'(PITCH_SLOTS);

  assign s1_has_result = (s1_cmd == CMD_NOTE_OFF) ||
                         ((s1_cmd == CMD_DAMPER) && !s1_pedal_down);
  assign s1_hold  = s1_valid && s1_has_result && out_valid && out_stall;
  assign s1_fire  = s1_valid && !s1_hold;
  assign in_stall = s1_hold;
  assign accept   = in_valid && !in_stall;

  assign ram_we    = s1_fire && (s1_cmd == CMD_NOTE_ON) && s1_in_range;
  assign ram_wdata = '{volume: s1_vel, start: s1_now};
  assign slot_hit  = s1_in_range && slot_valid[s1_idx];

  mnt_slot_ram #(
    .DEPTH (PITCH_SLOTS),
    .IDX_W (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    res_kind   = KIND_OFF_NO_ON;
    res_pitch  = '0;
    res_volume = '0;
    res_start  = '0;
    case (s1_cmd)
      CMD_NOTE_OFF: begin
        if (slot_hit) begin
          res_kind   = KIND_NOTE;
          res_pitch  = s1_pitch;
          res_volume = ram_rdata.volume;
          res_start  = ram_rdata.start;
        end
      end
      CMD_DAMPER: begin
        if (damper_held) begin
          res_kind  = KIND_DAMPER_SPAN;
          res_start = damper_start;
        end else begin
          res_kind = KIND_UP_NO_DOWN;
        end
      end
      default: begin
        res_kind = KIND_OFF_NO_ON;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      s1_valid     <= 1'b0;
      slot_valid   <= '0;
      damper_held  <= 1'b0;
      damper_start <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        tick_count <= tick_next;
      end

      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire && s1_in_range) begin
        if (s1_cmd == CMD_NOTE_ON) begin
          slot_valid[s1_idx] <= 1'b1;
        end else if (s1_cmd == CMD_NOTE_OFF) begin
          slot_valid[s1_idx] <= 1'b0;
        end
      end

      if (s1_fire && (s1_cmd == CMD_DAMPER)) begin
        if (s1_pedal_down) begin
          damper_held  <= 1'b1;
          damper_start <= s1_now;
        end else begin
          damper_held <= 1'b0;
        end
      end

      if (s1_fire && s1_has_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd        <= cmd_t'(cmd);
      s1_pitch      <= pitch_or_pedal;
      s1_idx        <= in_idx;
      s1_in_range   <= in_range;
      s1_pedal_down <= (pitch_or_pedal != '0);
      s1_vel        <= velocity;
      s1_now        <= tick_next;
    end
    if (s1_fire && s1_has_result) begin
      kind        <= res_kind;
      note_pitch  <= res_pitch;
      note_volume <= res_volume;
      start_tick  <= res_start;
      stop_tick   <= s1_now;
    end
  end

endmodule

`default_nettype wire

### src/mnt_checker.sv
// ----------------------------------------------------------------------------
// mnt_checker
// port-level checks for the midi note tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mnt_checker
  import mnt_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         kind,
  input wire logic [PITCH_W-1:0] note_pitch,
  input wire logic [VOL_W-1:0]   note_volume,
  input wire logic [TICK_W-1:0]  start_tick,
  input wire logic [TICK_W-1:0]  stop_tick
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(start_tick) &&
      $stable(stop_tick) && $stable(note_pitch) && $stable(note_volume))
    else $error("stalled result changed");

  // the input only stalls behind a full, stalled output
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // error results carry no pitch, volume or start
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((kind == KIND_OFF_NO_ON) || (kind == KIND_UP_NO_DOWN)) |->
      (note_pitch == '0) && (note_volume == '0) && (start_tick == '0))
    else $error("error result with payload");

  // a span never ends before it starts
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((kind == KIND_NOTE) || (kind == KIND_DAMPER_SPAN)) |->
      stop_tick >= start_tick)
    else $error("span stops before start");

endmodule

bind midi_event_to_note_tracker mnt_checker u_mnt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .note_pitch  (note_pitch),
  .note_volume (note_volume),
  .start_tick  (start_tick),
  .stop_tick   (stop_tick)
);

`default_nettype wire
